### src/ipfct_pkg.sv
// Shared constants and item types for the IP filter connection tracker.
`default_nettype none

package ipfct_pkg;

	localparam int unsigned TableEntries = 1024;
	localparam int unsigned TableAw      = $clog2(TableEntries);
	localparam int unsigned CountW       = $clog2(TableEntries + 1);
	localparam int unsigned QueueDepth   = 2;
	localparam int unsigned QueueAw      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned QueueCw      = $clog2(QueueDepth + 1);
	localparam int unsigned PairW        = 64;

	typedef struct packed {
		logic [31:0] src_address;
		logic [31:0] dst_address;
	} packet_t;

	typedef struct packed {
		logic forward;
		logic new_connection;
		logic stored;
		logic table_full;
	} verdict_t;

	// One classified item waiting for the table lookup.
	typedef struct packed {
		logic        forward;
		logic [31:0] src_address;
		logic [31:0] dst_address;
	} job_t;

	typedef struct packed {
		logic queue_empty;
		logic queue_full;
		logic back_idle;
	} status_t;

endpackage

`default_nettype wire

### src/ipfct_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ipfct_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### src/ipfct_front.sv
// Front end: watch address register, item acceptance and classification.
`default_nettype none

module ipfct_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire ipfct_pkg::packet_t packet,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [31:0]       cfg_data,
	input  wire ipfct_pkg::status_t status,
	output logic                   push,
	output ipfct_pkg::job_t        push_job
);

	import ipfct_pkg::*;

	logic [31:0] watch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			watch_q <= cfg_data;
		end
	end

	// The register may only change once everything downstream has drained.
	assign cfg_ready = status.queue_empty && status.back_idle;

	// No item is taken while a register write is offered, so an item is never
	// classified against a watch address that changes at the same edge.
	assign busy = status.queue_full || cfg_valid;
	assign push = start && !busy;

	assign push_job.forward     = (packet.src_address == watch_q) ||
	                              (packet.dst_address == watch_q);
	assign push_job.src_address = packet.src_address;
	assign push_job.dst_address = packet.dst_address;

endmodule

`default_nettype wire

### src/ipfct_queue.sv
// Short queue of classified items between the front and back ends.
`default_nettype none

module ipfct_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire ipfct_pkg::job_t push_job,
	input  wire logic            pop,
	output ipfct_pkg::job_t      pop_job,
	output logic                 empty,
	output logic                 full
);

	import ipfct_pkg::*;

	job_t               slot_q [QueueDepth];
	logic [QueueAw-1:0] wr_ptr_q;
	logic [QueueAw-1:0] rd_ptr_q;
	logic [QueueCw-1:0] count_q;

	function automatic logic [QueueAw-1:0] next_ptr(input logic [QueueAw-1:0] p);
		logic [QueueAw-1:0] r;
		if (p == QueueAw'(QueueDepth - 1)) begin
			r = '0;
		end else begin
			r = p + QueueAw'(1);
		end
		return r;
	endfunction

	assign empty   = (count_q == '0);
	assign full    = (count_q == QueueCw'(QueueDepth));
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QueueCw'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QueueCw'(1);
			end
		end
	end

endmodule

`default_nettype wire

### src/ipfct_back.sv
// Back end: sequential scan of the pair table, append of new pairs, result output.
`default_nettype none

module ipfct_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire ipfct_pkg::job_t    q_job,
	output logic                    pop,
	output logic                    idle,
	output logic [ipfct_pkg::CountW-1:0] fill_count,
	output logic                    done,
	output ipfct_pkg::verdict_t     verdict
);

	import ipfct_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [CountW-1:0] fill_q;
	logic [CountW-1:0] idx_q;
	logic              issuing_q;
	logic              cmp_vld_q;
	logic              done_q;
	verdict_t          verdict_q;

	logic              ram_re;
	logic              ram_we;
	logic [PairW-1:0]  ram_rdata;
	logic [31:0]       entry_src;
	logic [31:0]       entry_dst;
	logic              found;
	logic              decide;
	logic              room;
	logic [CountW-1:0] idx_next;

	ipfct_ram #(
		.Width (PairW),
		.Depth (TableEntries)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[TableAw-1:0]),
		.wdata ({job_q.src_address, job_q.dst_address}),
		.re    (ram_re),
		.raddr (idx_q[TableAw-1:0]),
		.rdata (ram_rdata)
	);

	assign entry_src = ram_rdata[PairW-1:32];
	assign entry_dst = ram_rdata[31:0];

	// A stored pair matches in either direction.
	assign found = (state_q == ST_SCAN) && cmp_vld_q &&
	               (((entry_src == job_q.src_address) && (entry_dst == job_q.dst_address)) ||
	                ((entry_src == job_q.dst_address) && (entry_dst == job_q.src_address)));

	assign decide   = (state_q == ST_SCAN) && !issuing_q && !cmp_vld_q;
	assign room     = (fill_q < CountW'(TableEntries));
	assign ram_re   = (state_q == ST_SCAN) && issuing_q && !found;
	assign ram_we   = decide && room;
	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign idx_next = idx_q + CountW'(1);

	assign idle       = (state_q == ST_IDLE);
	assign fill_count = fill_q;
	assign done       = done_q;
	assign verdict    = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			job_q     <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			issuing_q <= 1'b0;
			cmp_vld_q <= 1'b0;
			done_q    <= 1'b0;
			verdict_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						job_q <= q_job;
						if (!q_job.forward) begin
							done_q    <= 1'b1;
							verdict_q <= '0;
						end else begin
							state_q   <= ST_SCAN;
							idx_q     <= '0;
							issuing_q <= (fill_q != '0);
							cmp_vld_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (found) begin
						done_q                   <= 1'b1;
						verdict_q.forward        <= 1'b1;
						verdict_q.new_connection <= 1'b0;
						verdict_q.stored         <= 1'b0;
						verdict_q.table_full     <= 1'b0;
						state_q                  <= ST_IDLE;
					end else if (decide) begin
						done_q                   <= 1'b1;
						verdict_q.forward        <= 1'b1;
						verdict_q.new_connection <= 1'b1;
						verdict_q.stored         <= room;
						verdict_q.table_full     <= !room;
						if (room) begin
							fill_q <= fill_q + CountW'(1);
						end
						state_q <= ST_IDLE;
					end else begin
						cmp_vld_q <= issuing_q;
						if (issuing_q) begin
							idx_q <= idx_next;
							if (idx_next == fill_q) begin
								issuing_q <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/ip_filter_connection_tracker.sv
// Top level of the IP filter connection tracker: front end, item queue and table back end.
// Results: a packet that is not forwarded gives its result once the back end takes it from
// the queue; a forwarded one scans the table one entry per cycle and stops at the entry that
// holds its pair, or after all filled entries when the pair is absent.
// Throughput: one item per cycle when nothing is forwarded, otherwise set by the scan; busy is
// also high while a register write is offered. The receiver cannot stall the results.
// Reset clears the watch address, the fill count and the queue; table contents stay undefined.
`default_nettype none

module ip_filter_connection_tracker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire ipfct_pkg::packet_t packet,
	output logic                    done,
	output ipfct_pkg::verdict_t     verdict,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [31:0]        cfg_data
);

	import ipfct_pkg::*;

	// The front end classifies each item against the watch address as it is
	// accepted and places it in a short queue. The back end takes items from
	// the queue one at a time and performs the table lookup, so the front end
	// keeps accepting items while a long scan is under way, until the queue fills.

	logic              push;
	job_t              push_job;
	logic              pop;
	job_t              pop_job;
	status_t           status;
	logic              back_idle;
	logic              q_empty;
	logic              q_full;
	logic [CountW-1:0] fill_count;

	assign status.queue_empty = q_empty;
	assign status.queue_full  = q_full;
	assign status.back_idle   = back_idle;

	ipfct_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.packet    (packet),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.status    (status),
		.push      (push),
		.push_job  (push_job)
	);

	ipfct_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	// The back end owns the pair table and the fill count; entries at or above
	// the fill count are never read, so the table needs no clearing pass.
	ipfct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (pop_job),
		.pop        (pop),
		.idle       (back_idle),
		.fill_count (fill_count),
		.done       (done),
		.verdict    (verdict)
	);

	// The fill count never goes beyond the table size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count <= CountW'(TableEntries))
		else $error("fill count beyond table size");

	// A packet that is not forwarded carries no other flag.
	a_not_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !verdict.forward) |->
		(!verdict.new_connection && !verdict.stored && !verdict.table_full))
		else $error("flags set on a packet that was not forwarded");

	// A new connection is either stored or dropped, never both.
	a_new_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (verdict.new_connection == (verdict.stored ^ verdict.table_full)) &&
		!(verdict.stored && verdict.table_full))
		else $error("inconsistent new connection outcome");

	// The fill count moves only together with a stored result.
	a_fill_move: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_count != $past(fill_count)) |-> (done && verdict.stored))
		else $error("fill count changed without a stored pair");

endmodule

`default_nettype wire

### sim/ip_filter_connection_tracker_test.sv
// Self-checking testbench for the IP filter connection tracker, with its verdict scoreboard.
import ipfct_pkg::*;

class flow_scoreboard;
	logic [31:0]       watch;
	logic [31:0]       pair_src [TableEntries];
	logic [31:0]       pair_dst [TableEntries];
	logic [CountW-1:0] fill;
	verdict_t          expected [$];
	int unsigned       errors;
	int unsigned       checked;

	function new();
		watch   = '0;
		fill    = '0;
		errors  = 0;
		checked = 0;
	endfunction

	function void set_watch(logic [31:0] addr);
		watch = addr;
	endfunction

	function int unsigned pending();
		return expected.size();
	endfunction

	function bit is_full();
		return fill == CountW'(TableEntries);
	endfunction

	// Works out the verdict of an accepted packet and updates the pair table.
	function void note_packet(packet_t p);
		verdict_t v;
		bit       hit;
		v   = '0;
		hit = 1'b0;
		if (p.src_address == watch || p.dst_address == watch) begin
			v.forward = 1'b1;
			for (int i = 0; i < int'(fill); i++) begin
				if ((pair_src[i] == p.src_address && pair_dst[i] == p.dst_address) ||
				    (pair_src[i] == p.dst_address && pair_dst[i] == p.src_address)) begin
					hit = 1'b1;
					break;
				end
			end
			if (!hit) begin
				v.new_connection = 1'b1;
				if (!is_full()) begin
					pair_src[fill] = p.src_address;
					pair_dst[fill] = p.dst_address;
					fill++;
					v.stored = 1'b1;
				end else begin
					v.table_full = 1'b1;
				end
			end
		end
		expected.push_back(v);
	endfunction

	task report(string msg);
		$display("%0t ns: MISMATCH: %s", $time, msg);
		errors++;
	endtask

	task compare_flag(string field, logic got, logic want);
		if (got !== want)
			report($sformatf("verdict %0d: %s is %b, expected %b", checked, field, got, want));
	endtask

	task check_verdict(verdict_t got);
		verdict_t want;
		if (expected.size() == 0) begin
			report($sformatf("verdict %b arrived with no item outstanding", got));
		end else begin
			want = expected.pop_front();
			compare_flag("forward", got.forward, want.forward);
			compare_flag("new_connection", got.new_connection, want.new_connection);
			compare_flag("stored", got.stored, want.stored);
			compare_flag("table_full", got.table_full, want.table_full);
			checked++;
		end
	endtask
endclass

module ip_filter_connection_tracker_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Random part: at least this many items, and, up to a cap, it carries on until the table has been
	// full for a while, so that dropped pairs are exercised many times over.
	localparam int unsigned RandomItems    = 1150;
	localparam int unsigned AfterFullItems = 60;
	localparam int unsigned RandomCap      = 3000;
	localparam int unsigned PhaseItems     = 250;
	// A forwarded item scans the whole table in the worst case, so the quiet limit is
	// several table scans plus the longest gap the sender may leave.
	localparam int unsigned QuietLimit     = 8 * TableEntries + 64;
	localparam int unsigned TailCycles     = 16;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b1;
	logic        start     = 1'b0;
	logic        busy;
	packet_t     packet    = '0;
	logic        done;
	verdict_t    verdict;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data  = '0;

	flow_scoreboard flows;
	int unsigned    quiet_cycles = 0;
	packet_t        seen_pairs [$];

	ip_filter_connection_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.packet    (packet),
		.done      (done),
		.verdict   (verdict),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Verdicts are checked at the edge that ends their strobe cycle. The same edge also
	// feeds the quiet counter: any item, verdict or register write counts as progress.
	always @(posedge clk) begin
		if (arst_n && done)
			flows.check_verdict(verdict);
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
	end

	// Nothing has moved for far longer than the slowest scan could take.
	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("%0t ns: no item moved for %0d cycles, %0d verdicts outstanding",
		         $time, quiet_cycles, flows.pending());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic packet_t pair_of(logic [31:0] src, logic [31:0] dst);
		packet_t p;
		p.src_address = src;
		p.dst_address = dst;
		return p;
	endfunction

	// Offers one item and holds it until the block takes it. The start strobe is left
	// high so that a following item can go out on the very next cycle.
	task automatic drive_item(input packet_t p);
		start  <= 1'b1;
		packet <= p;
		do
			@(posedge clk);
		while (busy);
		flows.note_packet(p);
	endtask

	task automatic pause(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds the sender off until every outstanding verdict has come back. It always waits
	// for a clock edge, so start is never lowered and raised within the same step.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (flows.pending() != 0);
	endtask

	task automatic write_watch(input logic [31:0] addr);
		cfg_valid <= 1'b1;
		cfg_data  <= addr;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		flows.set_watch(addr);
	endtask

	function automatic int unsigned next_burst();
		return ($urandom_range(0, 3) == 0) ? $urandom_range(16, 64) : $urandom_range(1, 8);
	endfunction

	// A fresh pair around the watched address, on a random side. Now and then the partner
	// is the watched address itself, so that both addresses are equal.
	function automatic packet_t watched_pair(logic [31:0] watch);
		logic [31:0] other;
		other = ($urandom_range(0, 31) == 0) ? watch : 32'($urandom());
		return $urandom_range(0, 1) ? pair_of(watch, other) : pair_of(other, watch);
	endfunction

	// Traffic that misses the watched address, sometimes with equal addresses.
	function automatic packet_t stray_pair();
		logic [31:0] a;
		a = $urandom();
		return ($urandom_range(0, 7) == 0) ? pair_of(a, a) : pair_of(a, 32'($urandom()));
	endfunction

	// One earlier pair of this phase, in either direction.
	function automatic packet_t repeat_pair();
		packet_t p;
		p = seen_pairs[$urandom_range(0, seen_pairs.size() - 1)];
		return $urandom_range(0, 1) ? pair_of(p.dst_address, p.src_address) : p;
	endfunction

	initial begin
		packet_t     p;
		int unsigned sent;
		int unsigned after_full;
		int unsigned burst_left;
		int unsigned phase;
		int unsigned pick;
		logic [31:0] watch_now;

		arst_n <= 1'b0;
		flows = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The watch address starts at its reset value of zero. A pair is
		// found again in either direction, both addresses may be equal, and a pair stored
		// under one watch address is still in the table after the address changes.
		drive_item(pair_of(32'h0000_0001, 32'h0000_0002));
		drive_item(pair_of(32'h0000_0000, 32'h1234_5678));
		drive_item(pair_of(32'h1234_5678, 32'h0000_0000));
		drive_item(pair_of(32'h0000_0000, 32'h1234_5678));
		drive_item(pair_of(32'h0000_0000, 32'h0000_0000));
		drive_item(pair_of(32'h0000_0000, 32'h0000_0000));
		drive_item(pair_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		drain();

		write_watch(32'hFFFF_FFFF);
		drive_item(pair_of(32'hFFFF_FFFF, 32'h0000_0000));
		drive_item(pair_of(32'h0000_0000, 32'hFFFF_FFFF));
		drive_item(pair_of(32'hFFFF_FFFF, 32'hFFFF_FFFF));
		drive_item(pair_of(32'h1234_5678, 32'h0000_0000));
		drive_item(pair_of(32'hFFFF_FFFF, 32'h0000_0001));
		drive_item(pair_of(32'h7FFF_FFFF, 32'h8000_0000));
		drive_item(pair_of(32'h8000_0000, 32'hFFFF_FFFF));
		drive_item(pair_of(32'hFFFF_FFFF, 32'h8000_0000));
		drain();

		write_watch(32'h1234_5678);
		drive_item(pair_of(32'h1234_5678, 32'h0000_0000));
		drive_item(pair_of(32'hFFFF_FFFF, 32'h1234_5678));
		drive_item(pair_of(32'h1234_5678, 32'hFFFF_FFFF));

		// Random part. Until the table is full nearly every item is a fresh watched pair,
		// since only those fill it; after that, repeats and dropped pairs take over.
		// Each phase starts from an idle block with a new watch address, the extremes among
		// them. The sender works in bursts, with gaps that are mostly short but sometimes
		// long enough to land in the middle of a table scan.
		sent       = 0;
		after_full = 0;
		phase      = 0;
		watch_now  = '0;
		burst_left = next_burst();
		while ((sent < RandomItems || after_full < AfterFullItems) && sent < RandomCap) begin
			if (sent % PhaseItems == 0) begin
				phase++;
				drain();
				case (phase % 4)
					1: begin
						watch_now = 32'hFFFF_FFFF;
					end
					3: begin
						watch_now = 32'h0000_0000;
					end
					default: begin
						watch_now = $urandom();
					end
				endcase
				write_watch(watch_now);
				seen_pairs.delete();
			end

			pick = $urandom_range(0, 99);
			if (pick < (flows.is_full() ? 20 : 6)) begin
				p = stray_pair();
			end else if (pick < (flows.is_full() ? 60 : 14) && seen_pairs.size() != 0) begin
				p = repeat_pair();
			end else begin
				p = watched_pair(watch_now);
				seen_pairs.push_back(p);
			end

			if (flows.is_full())
				after_full++;
			drive_item(p);
			sent++;

			burst_left--;
			if (burst_left == 0) begin
				if ($urandom_range(0, 15) == 0)
					drain();
				else if ($urandom_range(0, 3) == 0)
					pause($urandom_range(1, int'(flows.fill) + 8));
				else
					pause($urandom_range(1, 6));
				burst_left = next_burst();
			end
		end

		drain();
		repeat (TailCycles) @(posedge clk);
		if (flows.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
